### rtl/sc2ch_pkg.sv
// Shared types, constants and keyboard translation tables for the scan code decoder.
package sc2ch_pkg;

   localparam int FIFO_DEPTH = 64;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   localparam int TABLE_LEN = 91;

   // Request opcodes.
   localparam logic OP_SCAN = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Layout codes.
   localparam logic LAYOUT_ENGLISH = 1'b0;
   localparam logic LAYOUT_SPANISH = 1'b1;

   // Special scan codes.
   localparam logic [7:0] SC_LSHIFT     = 8'h2A;
   localparam logic [7:0] SC_RSHIFT     = 8'h36;
   localparam logic [7:0] SC_LSHIFT_REL = 8'hAA;
   localparam logic [7:0] SC_RSHIFT_REL = 8'hB6;
   localparam logic [7:0] SC_CAPS       = 8'h3A;
   localparam logic [7:0] SC_DEAD       = 8'h1A;
   localparam logic [7:0] SC_LAST_XLAT  = 8'h82;

   localparam logic [7:0] SC_VOWEL_A = 8'h1E;
   localparam logic [7:0] SC_VOWEL_E = 8'h12;
   localparam logic [7:0] SC_VOWEL_I = 8'h17;
   localparam logic [7:0] SC_VOWEL_O = 8'h18;
   localparam logic [7:0] SC_VOWEL_U = 8'h16;

   typedef enum logic [1:0] {
      CMD_NONE = 2'd0,
      CMD_PUSH = 2'd1,
      CMD_POP  = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   char_code;
   } cmd_type;

   typedef struct packed {
      logic       opcode;
      logic [7:0] scan_code;
   } req_type;

   typedef struct packed {
      logic [7:0] read_char;
      logic       char_valid;
      logic       char_stored;
      logic       overflow;
      logic [6:0] fill_level;
   } rsp_type;

   // English layout: upper byte is the shifted column, lower byte the plain column.
   localparam logic [15:0] ENG_MAP [0:TABLE_LEN-1] = '{
      16'hFFFF, 16'hFEFE, 16'h2131, 16'h4032, 16'h2333, 16'h2434, 16'h2535, 16'h5E36,
      16'h2637, 16'h2A38, 16'h2839, 16'h2930, 16'h5F2D, 16'h2B3D, 16'h0808, 16'h0909,
      16'h5171, 16'h5777, 16'h4565, 16'h5272, 16'h5474, 16'h5979, 16'h5575, 16'h4969,
      16'h4F6F, 16'h5070, 16'h7B5B, 16'h7D5D, 16'h0A0A, 16'hFFFF, 16'h4161, 16'h5373,
      16'h4464, 16'h4666, 16'h4767, 16'h4868, 16'h4A6A, 16'h4B6B, 16'h4C6C, 16'h3A3B,
      16'h2227, 16'h7E60, 16'hFFFF, 16'h7C5C, 16'h5A7A, 16'h5878, 16'h4363, 16'h5676,
      16'h4262, 16'h4E6E, 16'h4D6D, 16'h3C2C, 16'h3E2E, 16'h3F2F, 16'hFFFF, 16'h2A2A,
      16'hFFFF, 16'h2020, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h3737,
      16'h3838, 16'h3939, 16'h2D2D, 16'h3434, 16'h3535, 16'h3636, 16'h2B2B, 16'h3131,
      16'h3232, 16'h3333, 16'h3030, 16'h2E2E, 16'hFFFF, 16'h2B2A, 16'h2B2A, 16'hFFFF,
      16'hFFFF, 16'h2B2A, 16'h2B2A
   };

   // Translates a code through the selected layout. Codes beyond the table give zero.
   function automatic logic [7:0] char_lookup(input logic layout, input logic [7:0] code,
                                              input logic lower);
      logic [15:0] pair;
      pair = 16'h0000;
      if (code < 8'(TABLE_LEN)) begin
         pair = ENG_MAP[code[6:0]];
         if (layout == LAYOUT_SPANISH) begin
            case (code[6:0])
               7'h03:   pair = 16'h2232;
               7'h04:   pair = 16'hF933;
               7'h07:   pair = 16'h2636;
               7'h08:   pair = 16'h2F37;
               7'h09:   pair = 16'h2838;
               7'h0A:   pair = 16'h2939;
               7'h0B:   pair = 16'h3D30;
               7'h0C:   pair = 16'h3F27;
               7'h0D:   pair = 16'hA8AD;
               7'h1A:   pair = 16'h5E60;
               7'h1B:   pair = 16'h2A2B;
               7'h27:   pair = 16'hA5A4;
               7'h28:   pair = 16'hFFFF;
               7'h29:   pair = 16'hA6A7;
               7'h2B:   pair = 16'h8087;
               7'h33:   pair = 16'h3B2C;
               7'h34:   pair = 16'h3A2E;
               7'h35:   pair = 16'h5F2D;
               7'h37:   pair = 16'h2A2B;
               default: pair = ENG_MAP[code[6:0]];
            endcase
         end
      end
      return lower ? pair[7:0] : pair[15:8];
   endfunction

   // Accented vowel for a vowel key, zero for any other key.
   function automatic logic [7:0] accented_vowel(input logic [7:0] code);
      logic [7:0] vowel;
      case (code)
         SC_VOWEL_A: vowel = 8'hA0;
         SC_VOWEL_E: vowel = 8'h82;
         SC_VOWEL_I: vowel = 8'hA1;
         SC_VOWEL_O: vowel = 8'hA2;
         SC_VOWEL_U: vowel = 8'hA3;
         default:    vowel = 8'h00;
      endcase
      return vowel;
   endfunction

endpackage

### rtl/sc2ch_front.sv
// Front end: accepts requests, tracks modifier keys and translates scan codes into commands.
module sc2ch_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic               csr_write_data,
   input  logic               req_accept,
   input  sc2ch_pkg::req_type req_item,
   output sc2ch_pkg::cmd_type cmd_out
);

   logic layout_ff, layout_in;
   logic shift_released_ff, shift_released_in;
   logic caps_off_ff, caps_off_in;
   logic accent_pending_ff, accent_pending_in;
   logic [7:0] xlat_char;
   logic [7:0] vowel_char;

   assign layout_in = csr_write_enable ? csr_write_data : layout_ff;

   always_comb begin
      xlat_char  = sc2ch_pkg::char_lookup(layout_ff, req_item.scan_code,
                                          shift_released_ff & caps_off_ff);
      vowel_char = sc2ch_pkg::accented_vowel(req_item.scan_code);

      shift_released_in = shift_released_ff;
      caps_off_in       = caps_off_ff;
      accent_pending_in = accent_pending_ff;
      cmd_out.kind      = sc2ch_pkg::CMD_NONE;
      cmd_out.char_code = xlat_char;

      if (req_item.opcode == sc2ch_pkg::OP_READ) begin
         cmd_out.kind = sc2ch_pkg::CMD_POP;
      end else if (req_item.scan_code == sc2ch_pkg::SC_LSHIFT ||
                   req_item.scan_code == sc2ch_pkg::SC_RSHIFT) begin
         shift_released_in = 1'b0;
      end else if (req_item.scan_code == sc2ch_pkg::SC_LSHIFT_REL ||
                   req_item.scan_code == sc2ch_pkg::SC_RSHIFT_REL) begin
         shift_released_in = 1'b1;
      end else if (req_item.scan_code == sc2ch_pkg::SC_CAPS) begin
         caps_off_in = ~caps_off_ff;
      end else if (req_item.scan_code == sc2ch_pkg::SC_DEAD) begin
         accent_pending_in = 1'b1;
      end else if (req_item.scan_code <= sc2ch_pkg::SC_LAST_XLAT) begin
         cmd_out.kind = sc2ch_pkg::CMD_PUSH;
         if (layout_ff == sc2ch_pkg::LAYOUT_SPANISH) begin
            if (accent_pending_ff && vowel_char != 8'h00) begin
               cmd_out.char_code = vowel_char;
            end
            // The dead key is consumed by any translated code, even one that gets dropped.
            accent_pending_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff         <= sc2ch_pkg::LAYOUT_SPANISH;
         shift_released_ff <= 1'b1;
         caps_off_ff       <= 1'b1;
         accent_pending_ff <= 1'b0;
      end else begin
         layout_ff <= layout_in;
         if (req_accept) begin
            shift_released_ff <= shift_released_in;
            caps_off_ff       <= caps_off_in;
            accent_pending_ff <= accent_pending_in;
         end
      end
   end

endmodule

### rtl/sc2ch_queue.sv
// Short command queue that decouples the front end from the character buffer.
module sc2ch_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sc2ch_pkg::cmd_type push_cmd,
   input  logic               pop,
   output logic               full,
   output logic               head_valid,
   output sc2ch_pkg::cmd_type head_cmd
);

   sc2ch_pkg::cmd_type entry_ff [0:sc2ch_pkg::CMDQ_DEPTH-1];
   logic [sc2ch_pkg::CMDQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sc2ch_pkg::CMDQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sc2ch_pkg::CMDQ_CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == sc2ch_pkg::CMDQ_CNT_W'(sc2ch_pkg::CMDQ_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == sc2ch_pkg::CMDQ_PTR_W'(sc2ch_pkg::CMDQ_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == sc2ch_pkg::CMDQ_PTR_W'(sc2ch_pkg::CMDQ_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("command queue written while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("command queue read while empty");

endmodule

### rtl/sc2ch_back.sv
// Back end: character buffer with push and pop, and the registered result stage.
module sc2ch_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  sc2ch_pkg::cmd_type cmd_in,
   output logic               cmd_take,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output sc2ch_pkg::rsp_type rsp_payload
);

   logic [7:0] char_mem [0:sc2ch_pkg::FIFO_DEPTH-1];
   logic [7:0] mem_q_ff;
   logic [sc2ch_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sc2ch_pkg::FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sc2ch_pkg::FIFO_CNT_W-1:0] count_ff, count_in;
   logic rsp_valid_ff, rsp_valid_in;
   sc2ch_pkg::rsp_type rsp_ff, rsp_in;
   logic do_push;
   logic do_pop;
   logic buf_full;
   logic buf_empty;

   assign buf_full  = (count_ff == sc2ch_pkg::FIFO_CNT_W'(sc2ch_pkg::FIFO_DEPTH));
   assign buf_empty = (count_ff == '0);
   assign cmd_take  = cmd_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      do_push      = 1'b0;
      do_pop       = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd_take) begin
         rsp_valid_in       = 1'b1;
         rsp_in.read_char   = 8'h00;
         rsp_in.char_valid  = 1'b0;
         rsp_in.char_stored = 1'b0;
         rsp_in.overflow    = 1'b0;
         case (cmd_in.kind)
            sc2ch_pkg::CMD_PUSH: begin
               if (buf_full) begin
                  rsp_in.overflow = 1'b1;
               end else begin
                  do_push            = 1'b1;
                  rsp_in.char_stored = 1'b1;
               end
            end
            sc2ch_pkg::CMD_POP: begin
               if (!buf_empty) begin
                  do_pop            = 1'b1;
                  rsp_in.char_valid = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == sc2ch_pkg::FIFO_PTR_W'(sc2ch_pkg::FIFO_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == sc2ch_pkg::FIFO_PTR_W'(sc2ch_pkg::FIFO_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end
      rsp_in.fill_level = 7'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // The popped character comes straight out of the buffer's registered read port.
   always_ff @(posedge clock) begin
      if (do_push) begin
         char_mem[wr_ptr_ff] <= cmd_in.char_code;
      end
      if (cmd_take) begin
         mem_q_ff <= char_mem[rd_ptr_ff];
      end
   end

   always_comb begin
      rsp_payload           = rsp_ff;
      rsp_payload.read_char = rsp_ff.char_valid ? mem_q_ff : 8'h00;
   end

   assign rsp_valid = rsp_valid_ff;

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sc2ch_pkg::FIFO_CNT_W'(sc2ch_pkg::FIFO_DEPTH))
      else $error("character count beyond buffer depth");

   a_single_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $countones({rsp_ff.char_valid, rsp_ff.char_stored,
                                   rsp_ff.overflow}) <= 1)
      else $error("result reports more than one outcome");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      do_push |=> count_ff == $past(count_ff) + 1'b1)
      else $error("stored character not counted");

   a_overflow_only_full: assert property (@(posedge clock) disable iff (reset)
      cmd_take && rsp_in.overflow |-> buf_full)
      else $error("overflow flagged with room in the buffer");

endmodule

### rtl/scancode_to_char_fifo_unit.sv
// Top level of the scan code decoder with its character buffer.
//
//   Port group    Direction  Contents
//   req_*         in         opcode (scan event or read) and scan code byte
//   rsp_*         out        popped character, flags, buffer fill level
//   csr_*         in         layout select write (0 English, 1 Spanish)
//
// One item per cycle is sustained while req_stall is low; each transferred request passes
// through the command queue and then the result register before its result appears.
// The character buffer is a single memory with one write and one registered read port.
// Reset is synchronous: modifiers released, caps off, buffer empty, Spanish layout.
// req_stall rises only when the two-entry command queue is full, which happens
// only while rsp_stall holds the result register.
module scancode_to_char_fifo_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  sc2ch_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output sc2ch_pkg::rsp_type rsp_payload,
   input  logic               csr_write_enable,
   input  logic               csr_write_data
);

   logic               req_accept;
   logic               queue_full;
   logic               head_valid;
   logic               cmd_take;
   sc2ch_pkg::cmd_type front_cmd;
   sc2ch_pkg::cmd_type head_cmd;

   assign req_stall  = queue_full;
   assign req_accept = req_valid && !queue_full;

   sc2ch_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_accept       (req_accept),
      .req_item         (req_payload),
      .cmd_out          (front_cmd)
   );

   sc2ch_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept),
      .push_cmd   (front_cmd),
      .pop        (cmd_take),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   sc2ch_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (head_valid),
      .cmd_in      (head_cmd),
      .cmd_take    (cmd_take),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

### dv/tb.sv
// Self-checking testbench for the scan code decoder and its character buffer.
`timescale 1ns / 1ps

module tb;

   localparam int QUIET_LIMIT = 1000;
   localparam int HOLD_CYCLES = 80;
   localparam int N_DIRECTED  = 27;

   // Upper byte is the shifted column, lower byte the plain column.
   localparam logic [15:0] EN_KEYMAP [0:sc2ch_pkg::TABLE_LEN-1] = '{
      16'hFFFF, 16'hFEFE, 16'h2131, 16'h4032, 16'h2333, 16'h2434, 16'h2535, 16'h5E36,
      16'h2637, 16'h2A38, 16'h2839, 16'h2930, 16'h5F2D, 16'h2B3D, 16'h0808, 16'h0909,
      16'h5171, 16'h5777, 16'h4565, 16'h5272, 16'h5474, 16'h5979, 16'h5575, 16'h4969,
      16'h4F6F, 16'h5070, 16'h7B5B, 16'h7D5D, 16'h0A0A, 16'hFFFF, 16'h4161, 16'h5373,
      16'h4464, 16'h4666, 16'h4767, 16'h4868, 16'h4A6A, 16'h4B6B, 16'h4C6C, 16'h3A3B,
      16'h2227, 16'h7E60, 16'hFFFF, 16'h7C5C, 16'h5A7A, 16'h5878, 16'h4363, 16'h5676,
      16'h4262, 16'h4E6E, 16'h4D6D, 16'h3C2C, 16'h3E2E, 16'h3F2F, 16'hFFFF, 16'h2A2A,
      16'hFFFF, 16'h2020, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h3737,
      16'h3838, 16'h3939, 16'h2D2D, 16'h3434, 16'h3535, 16'h3636, 16'h2B2B, 16'h3131,
      16'h3232, 16'h3333, 16'h3030, 16'h2E2E, 16'hFFFF, 16'h2B2A, 16'h2B2A, 16'hFFFF,
      16'hFFFF, 16'h2B2A, 16'h2B2A
   };

   typedef struct packed {
      sc2ch_pkg::req_type item;
      logic               has_literal;
      sc2ch_pkg::rsp_type result;
   } directed_row_type;

   // Rows with a typed-in result can be read off directly; the others use the predictor.
   localparam directed_row_type DIRECTED [0:N_DIRECTED-1] = '{
      '{'{sc2ch_pkg::OP_READ, 8'h00}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 7'd0}},
      '{'{sc2ch_pkg::OP_SCAN, 8'h00}, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 7'd1}},
      '{'{sc2ch_pkg::OP_SCAN, 8'h01}, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 7'd2}},
      '{'{sc2ch_pkg::OP_SCAN, 8'hFF}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 7'd2}},
      '{'{sc2ch_pkg::OP_SCAN, 8'hA0}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 7'd2}},
      '{'{sc2ch_pkg::OP_SCAN, 8'hA3}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 7'd2}},
      '{'{sc2ch_pkg::OP_READ, 8'hFF}, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0, 7'd1}},
      '{'{sc2ch_pkg::OP_SCAN, sc2ch_pkg::SC_DEAD}, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, 7'd1}},
      '{'{sc2ch_pkg::OP_SCAN, sc2ch_pkg::SC_VOWEL_E}, 1'b0, '0},
      '{'{sc2ch_pkg::OP_SCAN, sc2ch_pkg::SC_DEAD}, 1'b0, '0},
      '{'{sc2ch_pkg::OP_SCAN, sc2ch_pkg::SC_VOWEL_A}, 1'b0, '0},
      '{'{sc2ch_pkg::OP_SCAN, sc2ch_pkg::SC_DEAD}, 1'b0, '0},
      '{'{sc2ch_pkg::OP_SCAN, 8'h10}, 1'b0, '0},
      '{'{sc2ch_pkg::OP_SCAN, sc2ch_pkg::SC_VOWEL_U}, 1'b0, '0},
      '{'{sc2ch_pkg::OP_SCAN, sc2ch_pkg::SC_LSHIFT}, 1'b0, '0},
      '{'{sc2ch_pkg::OP_SCAN, sc2ch_pkg::SC_VOWEL_A}, 1'b0, '0},
      '{'{sc2ch_pkg::OP_SCAN, sc2ch_pkg::SC_LSHIFT_REL}, 1'b0, '0},
      '{'{sc2ch_pkg::OP_SCAN, sc2ch_pkg::SC_CAPS}, 1'b0, '0},
      '{'{sc2ch_pkg::OP_SCAN, 8'h02}, 1'b0, '0},
      '{'{sc2ch_pkg::OP_SCAN, sc2ch_pkg::SC_CAPS}, 1'b0, '0},
      '{'{sc2ch_pkg::OP_SCAN, sc2ch_pkg::SC_RSHIFT}, 1'b0, '0},
      '{'{sc2ch_pkg::OP_SCAN, sc2ch_pkg::SC_RSHIFT_REL}, 1'b0, '0},
      '{'{sc2ch_pkg::OP_SCAN, sc2ch_pkg::SC_LAST_XLAT}, 1'b0, '0},
      '{'{sc2ch_pkg::OP_SCAN, 8'h5A}, 1'b0, '0},
      '{'{sc2ch_pkg::OP_SCAN, 8'h5B}, 1'b0, '0},
      '{'{sc2ch_pkg::OP_SCAN, 8'h83}, 1'b0, '0},
      '{'{sc2ch_pkg::OP_READ, 8'h00}, 1'b0, '0}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   sc2ch_pkg::req_type req_payload = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   sc2ch_pkg::rsp_type rsp_payload;
   logic               csr_write_enable = 1'b0;
   logic               csr_write_data = 1'b0;

   // Predictor state.
   logic       kb_layout = sc2ch_pkg::LAYOUT_SPANISH;
   logic       shift_up = 1'b1;
   logic       caps_clear = 1'b1;
   logic       accent_armed = 1'b0;
   logic [7:0] char_fifo [$];

   sc2ch_pkg::rsp_type pending_results [$];
   sc2ch_pkg::rsp_type head_result;
   int      mismatches = 0;
   int      quiet_cycles = 0;
   bit      sender_gaps = 1'b1;
   bit      receiver_gaps = 1'b1;
   bit      hold_request = 1'b0;

   scancode_to_char_fifo_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #1 clock = ~clock;

   function automatic logic [15:0] key_pair(input logic layout, input logic [7:0] code);
      logic [15:0] pair;
      pair = 16'h0000;
      if (code < sc2ch_pkg::TABLE_LEN) begin
         pair = EN_KEYMAP[code[6:0]];
         if (layout == sc2ch_pkg::LAYOUT_SPANISH) begin
            case (code)
               8'h03: pair = 16'h2232;
               8'h04: pair = 16'hF933;
               8'h07: pair = 16'h2636;
               8'h08: pair = 16'h2F37;
               8'h09: pair = 16'h2838;
               8'h0A: pair = 16'h2939;
               8'h0B: pair = 16'h3D30;
               8'h0C: pair = 16'h3F27;
               8'h0D: pair = 16'hA8AD;
               8'h1A: pair = 16'h5E60;
               8'h1B: pair = 16'h2A2B;
               8'h27: pair = 16'hA5A4;
               8'h28: pair = 16'hFFFF;
               8'h29: pair = 16'hA6A7;
               8'h2B: pair = 16'h8087;
               8'h33: pair = 16'h3B2C;
               8'h34: pair = 16'h3A2E;
               8'h35: pair = 16'h5F2D;
               8'h37: pair = 16'h2A2B;
               default: ;
            endcase
         end
      end
      return pair;
   endfunction

   function automatic logic [7:0] accent_for(input logic [7:0] code);
      case (code)
         sc2ch_pkg::SC_VOWEL_A: return 8'hA0;
         sc2ch_pkg::SC_VOWEL_E: return 8'h82;
         sc2ch_pkg::SC_VOWEL_I: return 8'hA1;
         sc2ch_pkg::SC_VOWEL_O: return 8'hA2;
         sc2ch_pkg::SC_VOWEL_U: return 8'hA3;
         default:               return 8'h00;
      endcase
   endfunction

   // Advances the predicted keyboard and buffer state by one transfer.
   function automatic sc2ch_pkg::rsp_type decode_keystroke(input sc2ch_pkg::req_type item);
      sc2ch_pkg::rsp_type r;
      logic [15:0]        pair;
      logic [7:0]         ch;
      logic [7:0]         acc;
      r = '0;
      if (item.opcode == sc2ch_pkg::OP_READ) begin
         if (char_fifo.size() > 0) begin
            r.read_char = char_fifo.pop_front();
            r.char_valid = 1'b1;
         end
      end else if (item.scan_code == sc2ch_pkg::SC_LSHIFT ||
                   item.scan_code == sc2ch_pkg::SC_RSHIFT) begin
         shift_up = 1'b0;
      end else if (item.scan_code == sc2ch_pkg::SC_LSHIFT_REL ||
                   item.scan_code == sc2ch_pkg::SC_RSHIFT_REL) begin
         shift_up = 1'b1;
      end else if (item.scan_code == sc2ch_pkg::SC_CAPS) begin
         caps_clear = ~caps_clear;
      end else if (item.scan_code == sc2ch_pkg::SC_DEAD) begin
         accent_armed = 1'b1;
      end else if (item.scan_code <= sc2ch_pkg::SC_LAST_XLAT) begin
         pair = key_pair(kb_layout, item.scan_code);
         ch = (shift_up && caps_clear) ? pair[7:0] : pair[15:8];
         // The accent is consumed by any translated code, even one that is dropped.
         if (kb_layout == sc2ch_pkg::LAYOUT_SPANISH) begin
            acc = accent_for(item.scan_code);
            if (accent_armed && acc != 8'h00) begin
               ch = acc;
            end
            accent_armed = 1'b0;
         end
         if (char_fifo.size() >= sc2ch_pkg::FIFO_DEPTH) begin
            r.overflow = 1'b1;
         end else begin
            char_fifo.push_back(ch);
            r.char_stored = 1'b1;
         end
      end
      r.fill_level = 7'(char_fifo.size());
      return r;
   endfunction

   function automatic sc2ch_pkg::req_type random_keystroke(input int read_pct);
      sc2ch_pkg::req_type item;
      int                 pick;
      item.opcode = sc2ch_pkg::OP_SCAN;
      item.scan_code = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < read_pct) begin
         item.opcode = sc2ch_pkg::OP_READ;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            item.scan_code = $urandom_range(0, 1) ? sc2ch_pkg::SC_LSHIFT :
                                                    sc2ch_pkg::SC_RSHIFT;
         end else if (pick < 12) begin
            item.scan_code = $urandom_range(0, 1) ? sc2ch_pkg::SC_LSHIFT_REL :
                                                    sc2ch_pkg::SC_RSHIFT_REL;
         end else if (pick < 16) begin
            item.scan_code = sc2ch_pkg::SC_CAPS;
         end else if (pick < 24) begin
            item.scan_code = sc2ch_pkg::SC_DEAD;
         end else if (pick < 40) begin
            case ($urandom_range(0, 4))
               0:       item.scan_code = sc2ch_pkg::SC_VOWEL_A;
               1:       item.scan_code = sc2ch_pkg::SC_VOWEL_E;
               2:       item.scan_code = sc2ch_pkg::SC_VOWEL_I;
               3:       item.scan_code = sc2ch_pkg::SC_VOWEL_O;
               default: item.scan_code = sc2ch_pkg::SC_VOWEL_U;
            endcase
         end else if (pick < 82) begin
            item.scan_code = 8'($urandom_range(0, sc2ch_pkg::SC_LAST_XLAT));
         end else if (pick < 92) begin
            item.scan_code = 8'($urandom_range(sc2ch_pkg::SC_LAST_XLAT + 1, 255));
         end
      end
      return item;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer, where the
   // caller must drive req_valid again.
   task automatic offer_keystroke(input sc2ch_pkg::req_type item, input logic literal,
                                  input sc2ch_pkg::rsp_type literal_result);
      sc2ch_pkg::rsp_type predicted;
      if (sender_gaps && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      predicted = decode_keystroke(item);
      pending_results.push_back(literal ? literal_result : predicted);
      @(negedge clock);
   endtask

   task automatic run_random(input int count, input int read_pct);
      for (int n = 0; n < count; n++) begin
         offer_keystroke(random_keystroke(read_pct), 1'b0, '0);
      end
   endtask

   task automatic select_layout(input logic layout);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= layout;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      kb_layout = layout;
   endtask

   // Result side: random stall bursts, plus one long hold that backs up the whole block.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
            hold_request = 1'b0;
         end else if (receiver_gaps && $urandom_range(0, 6) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with no request outstanding");
            mismatches++;
         end else begin
            head_result = pending_results.pop_front();
            if (rsp_payload.read_char !== head_result.read_char) begin
               $error("read_char: expected %0h, actual %0h",
                      head_result.read_char, rsp_payload.read_char);
               mismatches++;
            end
            if (rsp_payload.char_valid !== head_result.char_valid) begin
               $error("char_valid: expected %0b, actual %0b",
                      head_result.char_valid, rsp_payload.char_valid);
               mismatches++;
            end
            if (rsp_payload.char_stored !== head_result.char_stored) begin
               $error("char_stored: expected %0b, actual %0b",
                      head_result.char_stored, rsp_payload.char_stored);
               mismatches++;
            end
            if (rsp_payload.overflow !== head_result.overflow) begin
               $error("overflow: expected %0b, actual %0b",
                      head_result.overflow, rsp_payload.overflow);
               mismatches++;
            end
            if (rsp_payload.fill_level !== head_result.fill_level) begin
               $error("fill_level: expected %0d, actual %0d",
                      head_result.fill_level, rsp_payload.fill_level);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $error("no transfer for %0d cycles", QUIET_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Reset leaves the Spanish layout selected.
      for (int i = 0; i < N_DIRECTED; i++) begin
         offer_keystroke(DIRECTED[i].item, DIRECTED[i].has_literal, DIRECTED[i].result);
      end

      select_layout(sc2ch_pkg::LAYOUT_ENGLISH);
      run_random(100, 45);

      // Mostly pushes so the buffer fills and overflows, starting under a long hold, then mostly reads.
      select_layout(sc2ch_pkg::LAYOUT_SPANISH);
      hold_request = 1'b1;
      run_random(130, 5);
      run_random(80, 90);

      select_layout(sc2ch_pkg::LAYOUT_ENGLISH);
      run_random(50, 50);

      select_layout(sc2ch_pkg::LAYOUT_SPANISH);
      sender_gaps = 1'b0;
      receiver_gaps = 1'b0;
      run_random(40, 50);

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
